// ----- hw/rtl/ots_pkg.sv -----
// shared types and constants for the ordered record table
package ots_pkg;

	localparam int DEPTH = 256;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;

	typedef enum logic [1:0] {
		OP_INSERT     = 2'd0,
		OP_REMOVE     = 2'd1,
		OP_SEQ_SEARCH = 2'd2,
		OP_BIN_SEARCH = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_POS   = 3'd1,
		ST_FULL      = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_PLACE,
		S_SCAN,
		S_PROBE,
		S_TEST
	} state_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [8:0]  position;
		logic [31:0] key;
		logic [63:0] name_word;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [8:0]  found_position;
		logic [31:0] found_key;
		logic [63:0] found_name;
		logic [8:0]  comparisons;
		logic [8:0]  moves;
	} res_t;

	typedef struct packed {
		logic [31:0] key;
		logic [63:0] name;
	} record_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		record_t       wdata;
		logic          re;
		logic [AW-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic eq;
		logic gt;
	} cmp_t;

	typedef struct packed {
		logic valid;
		res_t res;
	} fin_t;

endpackage

// ----- hw/rtl/ordered_table_insert_remove_search.sv -----
// insert/remove: later entries shift one slot; insert then writes the record
// sequential search: one record read per cycle until a match or the end
// binary search: probe reads then tests; errors report the cycle after start
// one request at a time, set by the single read port of the record store
// reset empties the table at once; record contents are left as they were
// top level of the ordered record table
module ordered_table_insert_remove_search (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ots_pkg::req_t  request,
	output logic           done,
	output ots_pkg::res_t  result
);

	ots_pkg::mem_req_t mreq;
	ots_pkg::record_t  rdata;
	ots_pkg::cmp_t     cmp;
	ots_pkg::fin_t     fin;
	logic [31:0]       cmp_key;
	logic              done_q;
	ots_pkg::res_t     result_q;

	ots_mem u_mem (
		.clk   (clk),
		.mreq  (mreq),
		.rdata (rdata)
	);

	ots_cmp u_cmp (
		.probe_key  (rdata.key),
		.search_key (cmp_key),
		.cmp        (cmp)
	);

	ots_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.mreq    (mreq),
		.rdata   (rdata),
		.cmp     (cmp),
		.cmp_key (cmp_key),
		.fin     (fin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.valid) begin
			result_q <= fin.res;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- hw/rtl/ots_mem.sv -----
// record store, one write and one registered read port
module ots_mem (
	input  logic               clk,
	input  ots_pkg::mem_req_t  mreq,
	output ots_pkg::record_t   rdata
);

	ots_pkg::record_t mem [ots_pkg::DEPTH];
	ots_pkg::record_t rdata_q;

	always_ff @(posedge clk) begin
		if (mreq.we) begin
			mem[mreq.waddr] <= mreq.wdata;
		end
		if (mreq.re) begin
			rdata_q <= mem[mreq.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/ots_cmp.sv -----
// shared key compare unit
module ots_cmp (
	input  logic [31:0]   probe_key,
	input  logic [31:0]   search_key,
	output ots_pkg::cmp_t cmp
);

	assign cmp.eq = (probe_key == search_key);
	assign cmp.gt = (probe_key > search_key);

endmodule

// ----- hw/rtl/ots_seq.sv -----
// sequencer for shifts, linear scan and binary probing
module ots_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ots_pkg::req_t     request,
	output logic              busy,
	output ots_pkg::mem_req_t mreq,
	input  ots_pkg::record_t  rdata,
	input  ots_pkg::cmp_t     cmp,
	output logic [31:0]       cmp_key,
	output ots_pkg::fin_t     fin
);

	localparam int AW = ots_pkg::AW;
	localparam int CW = ots_pkg::CW;

	ots_pkg::state_t state_q, state_d;
	ots_pkg::op_t    op_q, op_d;
	logic [31:0]     key_q, key_d;
	logic [63:0]     name_q, name_d;
	logic [CW-1:0]   pos_q, pos_d;
	logic [CW-1:0]   count_q, count_d;
	logic [AW-1:0]   addr_q, addr_d;
	logic [CW-1:0]   left_q, left_d;
	logic [CW-1:0]   mv_q, mv_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [CW-1:0]   low_q, low_d;
	logic [CW-1:0]   high_q, high_d;
	logic [AW-1:0]   mid_q, mid_d;
	ots_pkg::record_t cap_q, cap_d;

	logic            pend_s1;
	logic [AW-1:0]   waddr_s1;
	logic            skip_s1;
	logic [AW-1:0]   idx_s1;

	logic            issue;
	logic [AW-1:0]   waddr_n;
	logic            skip_n;
	logic [CW:0]     mid_sum;
	logic [CW:0]     pos_ext;
	logic [CW:0]     cnt_ext;
	logic [CW-1:0]   pos_m1;

	function automatic ots_pkg::res_t err_res(ots_pkg::status_t s);
		ots_pkg::res_t r;
		r = '0;
		r.status = s;
		return r;
	endfunction

	assign busy    = (state_q != ots_pkg::S_IDLE);
	assign cmp_key = key_q;
	assign mid_sum = {1'b0, low_q} + {1'b0, high_q};
	assign pos_ext = {1'b0, request.position};
	assign cnt_ext = {1'b0, count_q};
	assign pos_m1  = pos_q - CW'(1);

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		key_d   = key_q;
		name_d  = name_q;
		pos_d   = pos_q;
		count_d = count_q;
		addr_d  = addr_q;
		left_d  = left_q;
		mv_d    = mv_q;
		cnt_d   = cnt_q;
		low_d   = low_q;
		high_d  = high_q;
		mid_d   = mid_q;
		cap_d   = cap_q;
		issue   = 1'b0;
		waddr_n = '0;
		skip_n  = 1'b0;
		mreq    = '0;
		fin     = '0;
		unique case (state_q)
			ots_pkg::S_IDLE: begin
				if (start) begin
					op_d   = ots_pkg::op_t'(request.opcode);
					key_d  = request.key;
					name_d = request.name_word;
					pos_d  = request.position;
					cnt_d  = '0;
					unique case (ots_pkg::op_t'(request.opcode))
						ots_pkg::OP_INSERT: begin
							if (count_q == CW'(ots_pkg::DEPTH)) begin
								fin = '{valid: 1'b1, res: err_res(ots_pkg::ST_FULL)};
							end else if (request.position == '0 ||
									pos_ext > cnt_ext + (CW+1)'(1)) begin
								fin = '{valid: 1'b1, res: err_res(ots_pkg::ST_BAD_POS)};
							end else begin
								addr_d  = AW'(count_q - CW'(1));
								left_d  = count_q - request.position + CW'(1);
								mv_d    = count_q - request.position + CW'(1);
								state_d = ots_pkg::S_SHIFT;
							end
						end
						ots_pkg::OP_REMOVE: begin
							if (count_q == '0) begin
								fin = '{valid: 1'b1, res: err_res(ots_pkg::ST_EMPTY)};
							end else if (request.position == '0 ||
									request.position > count_q) begin
								fin = '{valid: 1'b1, res: err_res(ots_pkg::ST_BAD_POS)};
							end else begin
								addr_d  = AW'(request.position - CW'(1));
								left_d  = count_q - request.position + CW'(1);
								mv_d    = count_q - request.position;
								state_d = ots_pkg::S_SHIFT;
							end
						end
						ots_pkg::OP_SEQ_SEARCH: begin
							if (count_q == '0) begin
								fin = '{valid: 1'b1, res: err_res(ots_pkg::ST_EMPTY)};
							end else begin
								addr_d  = '0;
								left_d  = count_q;
								state_d = ots_pkg::S_SCAN;
							end
						end
						ots_pkg::OP_BIN_SEARCH: begin
							if (count_q == '0) begin
								fin = '{valid: 1'b1, res: err_res(ots_pkg::ST_EMPTY)};
							end else begin
								low_d   = '0;
								high_d  = count_q;
								state_d = ots_pkg::S_PROBE;
							end
						end
					endcase
				end
			end
			ots_pkg::S_SHIFT: begin
				if (pend_s1) begin
					if (skip_s1) begin
						cap_d = rdata;
					end else begin
						mreq.we    = 1'b1;
						mreq.waddr = waddr_s1;
						mreq.wdata = rdata;
					end
				end
				if (left_q != '0) begin
					issue      = 1'b1;
					mreq.re    = 1'b1;
					mreq.raddr = addr_q;
					left_d     = left_q - CW'(1);
					if (op_q == ots_pkg::OP_INSERT) begin
						addr_d  = addr_q - AW'(1);
						waddr_n = addr_q + AW'(1);
					end else begin
						addr_d  = addr_q + AW'(1);
						waddr_n = addr_q - AW'(1);
						skip_n  = ({1'b0, addr_q} == pos_m1);
					end
				end else if (op_q == ots_pkg::OP_INSERT) begin
					state_d = ots_pkg::S_PLACE;
				end else if (!pend_s1) begin
					fin.valid              = 1'b1;
					fin.res.status         = ots_pkg::ST_OK;
					fin.res.found_position = pos_q;
					fin.res.found_key      = cap_q.key;
					fin.res.found_name     = cap_q.name;
					fin.res.moves          = mv_q;
					count_d                = count_q - CW'(1);
					state_d                = ots_pkg::S_IDLE;
				end
			end
			ots_pkg::S_PLACE: begin
				mreq.we                = 1'b1;
				mreq.waddr             = AW'(pos_m1);
				mreq.wdata             = '{key: key_q, name: name_q};
				fin.valid              = 1'b1;
				fin.res.status         = ots_pkg::ST_OK;
				fin.res.found_position = pos_q;
				fin.res.found_key      = key_q;
				fin.res.found_name     = name_q;
				fin.res.moves          = mv_q;
				count_d                = count_q + CW'(1);
				state_d                = ots_pkg::S_IDLE;
			end
			ots_pkg::S_SCAN: begin
				if (left_q != '0) begin
					issue      = 1'b1;
					mreq.re    = 1'b1;
					mreq.raddr = addr_q;
					waddr_n    = addr_q;
					addr_d     = addr_q + AW'(1);
					left_d     = left_q - CW'(1);
				end
				if (pend_s1) begin
					cnt_d = cnt_q + CW'(1);
					if (cmp.eq) begin
						fin.valid              = 1'b1;
						fin.res.status         = ots_pkg::ST_OK;
						fin.res.found_position = {1'b0, idx_s1} + CW'(1);
						fin.res.found_key      = key_q;
						fin.res.found_name     = rdata.name;
						fin.res.comparisons    = cnt_q + CW'(1);
						state_d                = ots_pkg::S_IDLE;
					end else if (left_q == '0) begin
						fin.valid           = 1'b1;
						fin.res.status      = ots_pkg::ST_NOT_FOUND;
						fin.res.comparisons = cnt_q + CW'(1);
						state_d             = ots_pkg::S_IDLE;
					end
				end
			end
			ots_pkg::S_PROBE: begin
				if (low_q < high_q) begin
					mreq.re    = 1'b1;
					mreq.raddr = mid_sum[AW:1];
					mid_d      = mid_sum[AW:1];
					state_d    = ots_pkg::S_TEST;
				end else begin
					fin.valid           = 1'b1;
					fin.res.status      = ots_pkg::ST_NOT_FOUND;
					fin.res.comparisons = cnt_q;
					state_d             = ots_pkg::S_IDLE;
				end
			end
			ots_pkg::S_TEST: begin
				cnt_d = cnt_q + CW'(1);
				if (cmp.eq) begin
					fin.valid              = 1'b1;
					fin.res.status         = ots_pkg::ST_OK;
					fin.res.found_position = {1'b0, mid_q} + CW'(1);
					fin.res.found_key      = key_q;
					fin.res.found_name     = rdata.name;
					fin.res.comparisons    = cnt_q + CW'(1);
					state_d                = ots_pkg::S_IDLE;
				end else begin
					if (cmp.gt) begin
						high_d = {1'b0, mid_q};
					end else begin
						low_d = {1'b0, mid_q} + CW'(1);
					end
					state_d = ots_pkg::S_PROBE;
				end
			end
			default: begin
				state_d = ots_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ots_pkg::S_IDLE;
			count_q <= '0;
			low_q   <= '0;
			high_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			low_q   <= low_d;
			high_q  <= high_d;
			pend_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		key_q    <= key_d;
		name_q   <= name_d;
		pos_q    <= pos_d;
		addr_q   <= addr_d;
		left_q   <= left_d;
		mv_q     <= mv_d;
		cnt_q    <= cnt_d;
		mid_q    <= mid_d;
		cap_q    <= cap_d;
		waddr_s1 <= waddr_n;
		skip_s1  <= skip_n;
		idx_s1   <= waddr_n;
	end

endmodule

// ----- hw/rtl/ots_chk.sv -----
// port checker for the ordered record table and its bind
module ots_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input ots_pkg::res_t result
);

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted request neither busy nor done");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_busy_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ots_pkg::ST_BAD_POS ||
			result.status == ots_pkg::ST_FULL ||
			result.status == ots_pkg::ST_EMPTY)
		|-> result.found_position == '0 && result.comparisons == '0 &&
			result.moves == '0)
		else $error("error result with nonzero fields");

	a_ok_position: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ots_pkg::ST_OK |-> result.found_position != '0)
		else $error("ok result without a position");

endmodule

bind ordered_table_insert_remove_search ots_chk u_ots_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.result  (result)
);
